FILE: rtl/assert_macros.svh
// Assertion helpers used by chth_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/chth_pkg.sv
`default_nettype none
package chth_pkg;

	localparam int CMD_W = 2;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int STS_W = 3;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STS_W-1:0] STS_INSERTED  = 3'd0;
	localparam logic [STS_W-1:0] STS_REPLACED  = 3'd1;
	localparam logic [STS_W-1:0] STS_REMOVED   = 3'd2;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd3;
	localparam logic [STS_W-1:0] STS_FOUND     = 3'd4;
	localparam logic [STS_W-1:0] STS_FULL      = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key_in;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [VAL_W-1:0] value_out;
		logic             table_empty;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/chth_fifo.sv
`default_nettype none
module chth_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	// two-entry queue
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok)
				wr_q <= ~wr_q;
			if (pop_ok)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

FILE: rtl/chth_front.sv
`default_nettype none
module chth_front #(
	parameter int NUM_BUCKETS = 10,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire chth_pkg::req_t item,
	input  wire logic          hold,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_ready,
	output chth_pkg::req_t     out_item,
	output logic [BW-1:0]      out_bucket
);

	localparam int KW  = chth_pkg::KEY_W;
	localparam int NW  = $clog2(NUM_BUCKETS + 1);
	localparam int P2W = KW + NW;
	// floor((2^32-1)/N): quotient estimate is exact or one low
	localparam logic [31:0]   RECIP = 32'(64'hFFFF_FFFF / NUM_BUCKETS);
	localparam logic [KW-1:0] NB_K  = KW'(NUM_BUCKETS);

	logic                 vld_s1;
	chth_pkg::req_t       item_s1;
	logic [KW-1:0]        quo_s1;
	logic                 vld_s2;
	chth_pkg::req_t       item_s2;
	logic [KW-1:0]        qn_s2;
	logic                 en1;
	logic                 en2;
	logic                 acc;
	logic [KW+31:0]       prod1;
	logic [P2W-1:0]       prod2;
	logic [KW-1:0]        rem;
	logic [KW-1:0]        rem_fix;

	assign en2  = !vld_s2 || out_ready;
	assign en1  = !vld_s1 || en2;
	assign full = !en1 || hold;
	assign acc  = push && !full;

	assign prod1 = (KW + 32)'(item.key_in) * (KW + 32)'(RECIP);
	assign prod2 = P2W'(quo_s1) * P2W'(NUM_BUCKETS);

	// remainder lies in [0, 2N): one conditional subtract
	assign rem     = item_s2.key_in - qn_s2;
	assign rem_fix = (rem >= NB_K) ? (rem - NB_K) : rem;

	assign out_valid  = vld_s2;
	assign out_item   = item_s2;
	assign out_bucket = rem_fix[BW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1)
				vld_s1 <= acc;
			if (en2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= item;
			quo_s1  <= prod1[KW+31:32];
		end
		if (en2) begin
			item_s2 <= item_s1;
			qn_s2   <= prod2[KW-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/chth_back.sv
`default_nettype none
`include "assert_macros.svh"
module chth_back #(
	parameter int NUM_BUCKETS = 10,
	parameter int CHAIN_DEPTH = 8,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire chth_pkg::req_t item,
	input  wire logic [BW-1:0]  bucket,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output chth_pkg::rsp_t      res,
	output logic                clearing
);

	localparam int KW    = chth_pkg::KEY_W;
	localparam int VW    = chth_pkg::VAL_W;
	localparam int WAYW  = KW + VW;
	localparam int ROWW  = WAYW * CHAIN_DEPTH;
	localparam int SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
	localparam int CW    = $clog2(SLOTS + 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0]             state_q;
	logic [BW-1:0]          clr_q;
	logic [CW-1:0]          cnt_q;
	chth_pkg::req_t         cur_q;
	logic [BW-1:0]          cur_bkt_q;

	logic [ROWW-1:0]        kv_mem [NUM_BUCKETS];
	logic [CHAIN_DEPTH-1:0] vld_mem [NUM_BUCKETS];
	logic [ROWW-1:0]        kv_rd_q;
	logic [CHAIN_DEPTH-1:0] vld_rd_q;

	logic [CHAIN_DEPTH-1:0] hit_vec;
	logic [CHAIN_DEPTH-1:0] free_vec;
	logic [CHAIN_DEPTH-1:0] free_oh;
	logic [VW-1:0]          hit_val;
	logic                   hit;
	logic [ROWW-1:0]        new_kv;
	logic [CHAIN_DEPTH-1:0] new_vld;
	logic                   kv_we;
	logic [chth_pkg::STS_W-1:0] status;
	logic [VW-1:0]          vout;
	logic [CW-1:0]          cnt_nxt;
	logic                   vld_we;
	logic [BW-1:0]          vld_addr;
	logic [CHAIN_DEPTH-1:0] vld_wdata;
	logic                   ins_new;

	assign clearing = (state_q == S_CLEAR);
	assign q_pop    = (state_q == S_IDLE) && !q_empty && !res_full;
	assign res_push = (state_q == S_EXEC);

	// all ways of the bucket row compared at once
	always_comb begin
		hit_vec = '0;
		hit_val = '0;
		for (int w = 0; w < CHAIN_DEPTH; w++) begin
			hit_vec[w] = vld_rd_q[w] && (kv_rd_q[w*WAYW +: KW] == cur_q.key_in);
			if (hit_vec[w])
				hit_val = hit_val | kv_rd_q[w*WAYW+KW +: VW];
		end
		hit      = |hit_vec;
		free_vec = ~vld_rd_q;
		free_oh  = free_vec & (~free_vec + CHAIN_DEPTH'(1));
	end

	always_comb begin
		new_kv  = kv_rd_q;
		new_vld = vld_rd_q;
		kv_we   = 1'b0;
		status  = chth_pkg::STS_NOT_FOUND;
		vout    = '0;
		cnt_nxt = cnt_q;
		unique case (cur_q.cmd)
			chth_pkg::CMD_INSERT: begin
				kv_we = 1'b1;
				if (hit) begin
					status = chth_pkg::STS_REPLACED;
					for (int w = 0; w < CHAIN_DEPTH; w++) begin
						if (hit_vec[w])
							new_kv[w*WAYW+KW +: VW] = cur_q.value_in;
					end
				end else if (|free_vec) begin
					status  = chth_pkg::STS_INSERTED;
					new_vld = vld_rd_q | free_oh;
					cnt_nxt = cnt_q + CW'(1);
					for (int w = 0; w < CHAIN_DEPTH; w++) begin
						if (free_oh[w])
							new_kv[w*WAYW +: WAYW] = {cur_q.value_in, cur_q.key_in};
					end
				end else begin
					status = chth_pkg::STS_FULL;
				end
			end
			chth_pkg::CMD_REMOVE: begin
				if (hit) begin
					status  = chth_pkg::STS_REMOVED;
					new_vld = vld_rd_q & ~hit_vec;
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			chth_pkg::CMD_SEARCH: begin
				if (hit) begin
					status = chth_pkg::STS_FOUND;
					vout   = hit_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.status      = status;
	assign res.value_out   = vout;
	assign res.table_empty = (cnt_nxt == '0);

	assign vld_we    = clearing || res_push;
	assign vld_addr  = clearing ? clr_q : cur_bkt_q;
	assign vld_wdata = clearing ? '0 : new_vld;

	assign ins_new = res_push && (status == chth_pkg::STS_INSERTED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == BW'(NUM_BUCKETS - 1))
						state_q <= S_IDLE;
					else
						clr_q <= clr_q + BW'(1);
				end
				S_IDLE: begin
					if (q_pop)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					cnt_q   <= cnt_nxt;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= item;
			cur_bkt_q <= bucket;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			kv_rd_q <= kv_mem[bucket];
		if (res_push && kv_we)
			kv_mem[cur_bkt_q] <= new_kv;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			vld_rd_q <= vld_mem[bucket];
		if (vld_we)
			vld_mem[vld_addr] <= vld_wdata;
	end

	`ASSERT_PROP(a_res_after_pop, clk, arst_n, res_push |-> $past(q_pop))
	`ASSERT_PROP(a_one_in_flight, clk, arst_n, q_pop |=> !q_pop)
	`ASSERT_NEVER(a_quiet_clear, clk, arst_n, clearing && (q_pop || res_push))
	`ASSERT_PROP(a_insert_count, clk, arst_n, ins_new |=> (cnt_q == $past(cnt_q) + CW'(1)))

endmodule
`default_nettype wire

FILE: rtl/chained_hash_table.sv
// Chained hash table: key/value store with bounded buckets.
// Request channel: drive item and raise push; a transfer happens on a rising
//   edge with push high and full low. cmd selects insert, remove or search.
// Result channel: while empty is low, result holds the oldest response; it
//   transfers on a rising edge with pop high. Exactly one result per request,
//   in request order.
// Path: two front stages compute key mod NUM_BUCKETS, the request queue is
//   written, then the back end reads the bucket row and writes it back.
// Back end: takes a new request only once the read-modify-write of the last
//   bucket row in the single-ported row memory is done.
// Reset: arst_n clears control state; afterwards a clearing pass wipes the
//   valid bits one bucket row per cycle, with full held high.
// Stall: if the result side stops popping, the two-entry result queue fills,
//   the back end waits, the request queue and front stages fill, then full rises.
//   No transfer is lost or repeated.
`default_nettype none
module chained_hash_table #(
	parameter int NUM_BUCKETS = 10,
	parameter int CHAIN_DEPTH = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire chth_pkg::req_t item,
	output logic                empty,
	input  wire logic           pop,
	output chth_pkg::rsp_t      result
);

	localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int MIDW = $bits(chth_pkg::req_t) + BW;
	localparam int RSPW = $bits(chth_pkg::rsp_t);

	// front end -> request queue
	logic           fr_full;
	logic           fr_valid;
	chth_pkg::req_t fr_item;
	logic [BW-1:0]  fr_bucket;
	logic           mid_full;
	logic           mid_empty;
	logic [MIDW-1:0] mid_dout;

	// back end
	logic           be_pop;
	logic           be_push;
	chth_pkg::rsp_t be_res;
	logic           clearing;
	logic           res_full;
	logic [RSPW-1:0] res_dout;

	chth_front #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.hold      (clearing),
		.full      (fr_full),
		.out_valid (fr_valid),
		.out_ready (!mid_full),
		.out_item  (fr_item),
		.out_bucket(fr_bucket)
	);

	// request queue decouples bucket hashing from table access
	chth_fifo #(
		.WIDTH(MIDW)
	) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid),
		.din   ({fr_bucket, fr_item}),
		.full  (mid_full),
		.pop   (be_pop),
		.dout  (mid_dout),
		.empty (mid_empty)
	);

	chth_back #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (chth_pkg::req_t'(mid_dout[$bits(chth_pkg::req_t)-1:0])),
		.bucket   (mid_dout[MIDW-1 -: BW]),
		.q_empty  (mid_empty),
		.q_pop    (be_pop),
		.res_full (res_full),
		.res_push (be_push),
		.res      (be_res),
		.clearing (clearing)
	);

	// result queue lets the back end finish while the receiver stalls
	chth_fifo #(
		.WIDTH(RSPW)
	) u_rsp_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (be_push),
		.din   (be_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign full   = fr_full;
	assign result = chth_pkg::rsp_t'(res_dout);

endmodule
`default_nettype wire

FILE: tb/chained_hash_table_tb.sv
`timescale 1ns / 1ps

module chained_hash_table_tb;

	localparam int NUM_BUCKETS = 10;
	localparam int CHAIN_DEPTH = 8;
	localparam int RANDOM_ITEMS = 1500;
	// fill/drain phases alternate every this many random transfers
	localparam int PHASE_LEN = 150;
	// cmd code 3 is unused by the block; it must act as a no-op
	localparam logic [chth_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [chth_pkg::KEY_W-1:0] KEY_MAX = {chth_pkg::KEY_W{1'b1}};
	localparam int PRINT_CAP = 40;

	// Software mirror of the table. Tracks slot contents the same way the
	// block lays them out (bucket * ways + way) and keeps the expected
	// responses in transfer order.
	class hash_table_mirror;
		localparam int BUCKETS = NUM_BUCKETS;
		localparam int WAYS = CHAIN_DEPTH;
		logic [chth_pkg::KEY_W-1:0] slot_k [BUCKETS*WAYS];
		logic [chth_pkg::VAL_W-1:0] slot_v [BUCKETS*WAYS];
		bit               slot_used [BUCKETS*WAYS];
		int unsigned      live_entries;
		chth_pkg::rsp_t   expected_rsp [$];
		int               errors;
		int               checked;
		int               outcome_cnt [8];

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_k[i] = '0;
				slot_v[i] = '0;
			end
			foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
			live_entries = 0;
			errors = 0;
			checked = 0;
		endfunction

		// Apply one request to the mirror and return the response it should give.
		function chth_pkg::rsp_t apply_op(chth_pkg::req_t r);
			int unsigned k;
			int base;
			int hit;
			chth_pkg::rsp_t o;
			k = r.key_in;
			base = int'(k % BUCKETS) * WAYS;
			hit = -1;
			for (int w = 0; w < WAYS; w++) begin
				if (hit < 0 && slot_used[base+w] && slot_k[base+w] == r.key_in)
					hit = base + w;
			end
			o.status = chth_pkg::STS_NOT_FOUND;
			o.value_out = '0;
			case (r.cmd)
				chth_pkg::CMD_INSERT: begin
					if (hit >= 0) begin
						slot_v[hit] = r.value_in;
						o.status = chth_pkg::STS_REPLACED;
					end else begin
						// lowest free way wins; none free means bucket full
						o.status = chth_pkg::STS_FULL;
						for (int w = 0; w < WAYS; w++) begin
							if (o.status == chth_pkg::STS_FULL && !slot_used[base+w]) begin
								slot_used[base+w] = 1'b1;
								slot_k[base+w] = r.key_in;
								slot_v[base+w] = r.value_in;
								live_entries++;
								o.status = chth_pkg::STS_INSERTED;
							end
						end
					end
				end
				chth_pkg::CMD_REMOVE: begin
					if (hit >= 0) begin
						slot_used[hit] = 1'b0;
						live_entries--;
						o.status = chth_pkg::STS_REMOVED;
					end
				end
				chth_pkg::CMD_SEARCH: begin
					if (hit >= 0) begin
						o.value_out = slot_v[hit];
						o.status = chth_pkg::STS_FOUND;
					end
				end
				default: ;
			endcase
			o.table_empty = (live_entries == 0);
			return o;
		endfunction

		function void note_request(chth_pkg::req_t r);
			chth_pkg::rsp_t e;
			e = apply_op(r);
			expected_rsp.push_back(e);
			outcome_cnt[e.status]++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_result(chth_pkg::rsp_t got);
			chth_pkg::rsp_t want;
			if (expected_rsp.size() == 0) begin
				report($sformatf("result with nothing outstanding (status %0d)", got.status));
				return;
			end
			want = expected_rsp.pop_front();
			checked++;
			if (got.status !== want.status)
				report($sformatf("result %0d: status %0d, want %0d",
					checked, got.status, want.status));
			if (got.value_out !== want.value_out)
				report($sformatf("result %0d: value_out %08h, want %08h",
					checked, got.value_out, want.value_out));
			if (got.table_empty !== want.table_empty)
				report($sformatf("result %0d: table_empty %0b, want %0b",
					checked, got.table_empty, want.table_empty));
		endtask

		task final_check();
			if (expected_rsp.size() != 0)
				report($sformatf("%0d results never arrived", expected_rsp.size()));
		endtask

		function int outstanding();
			return expected_rsp.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	chth_pkg::req_t item;
	logic empty;
	logic pop;
	chth_pkg::rsp_t result;

	hash_table_mirror mirror = new();

	chained_hash_table #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.CHAIN_DEPTH(CHAIN_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop. Even the slowest legit run (1.5k transfers, idle gaps between
	// bursts, long receiver stalls) ends well inside this limit, which leaves
	// plenty of headroom, including the post-reset clear pass.
	initial begin
		#5_000_000;
		$display("TIMEOUT: %0d results still outstanding", mirror.outstanding());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request side. Inputs change on the falling edge; a transfer is taken
	// at the rising edge where push is high and full (pre-edge value) is low.
	// Back-to-back calls keep push high with a single assignment per edge.
	// ------------------------------------------------------------------
	task automatic push_request(chth_pkg::req_t r);
		@(negedge clk);
		item <= r;
		push <= 1'b1;
		do @(posedge clk); while (full);
		mirror.note_request(r);
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	function automatic chth_pkg::req_t mk_req(logic [chth_pkg::CMD_W-1:0] c,
			logic [chth_pkg::KEY_W-1:0] k, logic [chth_pkg::VAL_W-1:0] v);
		chth_pkg::req_t r;
		r.cmd = c;
		r.key_in = k;
		r.value_in = v;
		return r;
	endfunction

	// Keys mostly come from a small per-bucket pool (12 keys per bucket, more
	// than the 8 ways) so hits, replaces and full buckets are common. Buckets
	// 3 and 7 are hot. A slice of keys sits near the top of the key range,
	// and a few are fully random to toggle every key bit.
	function automatic logic [chth_pkg::KEY_W-1:0] pick_key();
		int sel;
		int bkt;
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			bkt = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) != 0) ? 3 : 7)
				: $urandom_range(0, NUM_BUCKETS - 1);
			return chth_pkg::KEY_W'(bkt + NUM_BUCKETS * $urandom_range(0, 11));
		end
		if (sel < 92)
			return KEY_MAX - chth_pkg::KEY_W'($urandom_range(0, 39));
		return chth_pkg::KEY_W'($urandom);
	endfunction

	function automatic logic [chth_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Fill phases lean on inserts; drain phases lean on removes so the
	// table gets back to empty now and then.
	function automatic logic [chth_pkg::CMD_W-1:0] pick_cmd(bit draining);
		int r;
		r = $urandom_range(0, 99);
		if (r < (draining ? 15 : 60)) return chth_pkg::CMD_INSERT;
		if (r < 75) return chth_pkg::CMD_REMOVE;
		if (r < 95) return chth_pkg::CMD_SEARCH;
		return CMD_UNUSED;
	endfunction

	initial begin : stim
		chth_pkg::req_t directed [$];
		int sent;
		int burst;
		int gap;
		int spins;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opener: empty-table misses, the unused code, key/value
		// extremes, replace in place, a bucket filled past its ways, and
		// reuse of a freed way.
		directed.push_back(mk_req(chth_pkg::CMD_SEARCH, '0, 32'h1234_5678));
		directed.push_back(mk_req(chth_pkg::CMD_REMOVE, '0, '1));
		directed.push_back(mk_req(CMD_UNUSED, '0, '0));
		directed.push_back(mk_req(chth_pkg::CMD_INSERT, '0, '0));
		directed.push_back(mk_req(chth_pkg::CMD_INSERT, '0, '1));
		directed.push_back(mk_req(chth_pkg::CMD_SEARCH, '0, '0));
		directed.push_back(mk_req(chth_pkg::CMD_INSERT, KEY_MAX, 32'hA5A5_A5A5));
		directed.push_back(mk_req(chth_pkg::CMD_SEARCH, KEY_MAX, '0));
		directed.push_back(mk_req(CMD_UNUSED, KEY_MAX, '1));
		// keys 3, 13, ... 83 all land in bucket 3; the ninth one has no room
		for (int i = 0; i < CHAIN_DEPTH + 1; i++)
			directed.push_back(mk_req(chth_pkg::CMD_INSERT,
				chth_pkg::KEY_W'(3 + NUM_BUCKETS * i), 32'h0100_0000 + i));
		directed.push_back(mk_req(chth_pkg::CMD_SEARCH,
			chth_pkg::KEY_W'(3 + NUM_BUCKETS * CHAIN_DEPTH), '0));
		directed.push_back(mk_req(chth_pkg::CMD_REMOVE, chth_pkg::KEY_W'(43), '0));
		directed.push_back(mk_req(chth_pkg::CMD_INSERT,
			chth_pkg::KEY_W'(3 + NUM_BUCKETS * CHAIN_DEPTH), 32'h5A5A_5A5A));
		directed.push_back(mk_req(chth_pkg::CMD_REMOVE, chth_pkg::KEY_W'(43), '0));
		directed.push_back(mk_req(chth_pkg::CMD_REMOVE, '0, '0));
		directed.push_back(mk_req(chth_pkg::CMD_REMOVE, KEY_MAX, '0));
		foreach (directed[i]) begin
			push_request(directed[i]);
			hold_off($urandom_range(0, 2));
		end

		// Random part: bursts of random length, idle gaps between them, and
		// a fair share of zero-length gaps so long back-to-back runs occur.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				push_request(mk_req(pick_cmd((sent / PHASE_LEN) % 2 == 1),
					pick_key(), pick_value()));
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			hold_off(gap);
		end
		hold_off(1);

		// Drain: wait for every expected result, then keep the clock running in
		// case something stray shows up after the last one.
		spins = 0;
		while (mirror.outstanding() > 0 && spins < 200_000) begin
			@(posedge clk);
			spins++;
		end
		repeat (32) @(posedge clk);
		mirror.final_check();

		$display("Checked %0d results over %0d directed and %0d random transfers.",
			mirror.checked, directed.size(), RANDOM_ITEMS);
		$display("Outcomes: %0d new, %0d replaced, %0d removed, %0d missing, %0d found, %0d full",
			mirror.outcome_cnt[chth_pkg::STS_INSERTED],
			mirror.outcome_cnt[chth_pkg::STS_REPLACED],
			mirror.outcome_cnt[chth_pkg::STS_REMOVED],
			mirror.outcome_cnt[chth_pkg::STS_NOT_FOUND],
			mirror.outcome_cnt[chth_pkg::STS_FOUND],
			mirror.outcome_cnt[chth_pkg::STS_FULL]);
		if (mirror.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side. Stall behavior switches at random between modes: always
	// pop, coin flip, mostly stalled, mostly popping. The mostly-stalled
	// mode backs up the result queue all the way to full.
	// ------------------------------------------------------------------
	initial begin : drain_side
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) != 0);
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= ($urandom_range(0, 3) != 0);
			endcase
			@(posedge clk);
			if (pop && !empty)
				mirror.check_result(result);
		end
	end

endmodule

FILE: chained_hash_table.f
+incdir+rtl
rtl/chth_pkg.sv
rtl/chth_fifo.sv
rtl/chth_front.sv
rtl/chth_back.sv
rtl/chained_hash_table.sv
tb/chained_hash_table_tb.sv
